FILE: src/mask_density_box_filter_assert.svh
// ---------------------------------------------------------------------------
// Mask density box filter: assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MASK_DENSITY_BOX_FILTER_ASSERT_SVH
`define MASK_DENSITY_BOX_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
`define MDBF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mdbf assertion failed");
`define MDBF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mdbf assertion failed");
`else
`define MDBF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MDBF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: src/mdbf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mask density box filter: package
// Shared widths, register map, reset values and inter-module structs.
// ---------------------------------------------------------------------------
package mdbf_pkg;

  localparam int MAX_RADIUS = 15;
  localparam int MAX_WIDTH  = 1024;

  localparam int PIX_W    = 8;
  localparam int DENS_W   = 8;
  localparam int POS_W    = 10;
  localparam int ROW_W    = 11;
  localparam int RADIUS_W = 4;
  localparam int LWIDTH_W = 11;
  localparam int SCALE_W  = 24;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam int SCALE_FRAC  = 16;
  localparam int DENSITY_MAX = 255;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1);
  localparam logic [LWIDTH_W-1:0] LWIDTH_RST = LWIDTH_W'(640);
  localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(1856854);

  typedef enum logic [1:0] {
    REG_RADIUS     = 2'd0,
    REG_LINE_WIDTH = 2'd1,
    REG_SCALE      = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic load;
    logic emit;
    logic use_old;
    logic frame_start;
  } scan_ctrl_t;

  typedef struct packed {
    logic b_valid;
    logic b_emit;
    logic b_adv;
  } accum_stat_t;

endpackage

FILE: src/mdbf_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mask density box filter: stream interfaces
// Pixel request channel and density result channel, valid/ready.
// ---------------------------------------------------------------------------
interface mdbf_in_if;
  logic                       valid;
  logic                       ready;
  logic [mdbf_pkg::PIX_W-1:0] mask_pixel;
  logic                       is_padding;
  logic                       frame_start;

  modport source (output valid, mask_pixel, is_padding, frame_start, input ready);
  modport sink   (input valid, mask_pixel, is_padding, frame_start, output ready);
endinterface

interface mdbf_out_if;
  logic                        valid;
  logic                        ready;
  logic [mdbf_pkg::DENS_W-1:0] density;
  logic [mdbf_pkg::POS_W-1:0]  out_row;
  logic [mdbf_pkg::POS_W-1:0]  out_col;

  modport source (output valid, density, out_row, out_col, input ready);
  modport sink   (input valid, density, out_row, out_col, output ready);
endinterface

FILE: src/mdbf_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mask density box filter: configuration registers
// APB register file holding radius, line width and scale.
// ---------------------------------------------------------------------------
module mdbf_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mdbf_pkg::ADDR_W-1:0]         paddr,
  input  logic [mdbf_pkg::DATA_W-1:0]         pwdata,
  output logic [mdbf_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  output logic [mdbf_pkg::RADIUS_W-1:0]       radius_o,
  output logic [mdbf_pkg::LWIDTH_W-1:0]       line_width_o,
  output logic [mdbf_pkg::SCALE_W-1:0]        scale_o
);

  logic [mdbf_pkg::RADIUS_W-1:0] radius_q;
  logic [mdbf_pkg::LWIDTH_W-1:0] lwidth_q;
  logic [mdbf_pkg::SCALE_W-1:0]  scale_q;
  logic                          wr_en;
  logic [1:0]                    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= mdbf_pkg::RADIUS_RST;
      lwidth_q <= mdbf_pkg::LWIDTH_RST;
      scale_q  <= mdbf_pkg::SCALE_RST;
    end else if (wr_en) begin
      unique case (mdbf_pkg::reg_idx_e'(idx))
        mdbf_pkg::REG_RADIUS:     radius_q <= pwdata[mdbf_pkg::RADIUS_W-1:0];
        mdbf_pkg::REG_LINE_WIDTH: lwidth_q <= pwdata[mdbf_pkg::LWIDTH_W-1:0];
        mdbf_pkg::REG_SCALE:      scale_q  <= pwdata[mdbf_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (mdbf_pkg::reg_idx_e'(idx))
      mdbf_pkg::REG_RADIUS:     prdata = mdbf_pkg::DATA_W'(radius_q);
      mdbf_pkg::REG_LINE_WIDTH: prdata = mdbf_pkg::DATA_W'(lwidth_q);
      mdbf_pkg::REG_SCALE:      prdata = mdbf_pkg::DATA_W'(scale_q);
      default:                  prdata = '0;
    endcase
  end

  assign radius_o     = radius_q;
  assign line_width_o = lwidth_q;
  assign scale_o      = scale_q;

endmodule

FILE: src/mdbf_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mask density box filter: raster scan front end
// Tracks row, column and line slot, keeps the horizontal running sum
// and derives line store addresses for each accepted pixel.
// ---------------------------------------------------------------------------
module mdbf_scan #(
  parameter int MAX_RADIUS = mdbf_pkg::MAX_RADIUS,
  parameter int MAX_WIDTH  = mdbf_pkg::MAX_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  logic [mdbf_pkg::PIX_W-1:0]             mask_pixel_i,
  input  logic                                   is_padding_i,
  input  logic                                   frame_start_i,
  input  logic [mdbf_pkg::RADIUS_W-1:0]          radius_i,
  input  logic [mdbf_pkg::LWIDTH_W-1:0]          line_width_i,
  output mdbf_pkg::scan_ctrl_t                   ctrl_o,
  output logic                                   pix_o,
  output logic                                   centre_we_o,
  output logic [$clog2(MAX_WIDTH)-1:0]           x_o,
  output logic [$clog2(MAX_WIDTH)-1:0]           col_o,
  output logic [$clog2(2*MAX_RADIUS+1)-1:0]      slot_o,
  output logic [$clog2(2*MAX_RADIUS+1)-1:0]      cslot_o,
  output logic [$clog2(2*MAX_RADIUS+2)-1:0]      hsum_o,
  output logic [mdbf_pkg::POS_W-1:0]             out_row_o,
  output logic [mdbf_pkg::POS_W-1:0]             out_col_o
);

  localparam int WIN_MAX = 2 * MAX_RADIUS + 1;
  localparam int RW      = $clog2(MAX_RADIUS + 1);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int XW      = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
  localparam int SW      = $clog2(WIN_MAX);
  localparam int WNW     = $clog2(WIN_MAX + 1);
  localparam int HW      = $clog2(WIN_MAX + 1);
  localparam int ROW_W   = mdbf_pkg::ROW_W;

  logic [XW-1:0]      col_q;
  logic [ROW_W-1:0]   row_q;
  logic [SW-1:0]      slot_q;
  logic [HW-1:0]      hsum_q;
  logic [WIN_MAX-1:0] dly_q;

  logic [RW-1:0]      r_eff;
  logic [WW-1:0]      w_eff;
  logic [WNW-1:0]     win;
  logic [XW-1:0]      col_b;
  logic [ROW_W-1:0]   row_b;
  logic [SW-1:0]      slot_b;
  logic [HW-1:0]      hsum_b;
  logic [WIN_MAX-1:0] dly_b;
  logic               pix;
  logic               leaving;
  logic [HW-1:0]      hsum_n;
  logic [XW-1:0]      c_full;
  logic               past_r;

  always_comb begin
    if (radius_i == '0) begin
      r_eff = RW'(1);
    end else if (32'(radius_i) > MAX_RADIUS) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(radius_i);
    end
    if (line_width_i == '0) begin
      w_eff = WW'(1);
    end else if (32'(line_width_i) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(line_width_i);
    end
    win = WNW'({1'b0, r_eff, 1'b1});

    col_b  = col_q;
    row_b  = row_q;
    slot_b = slot_q;
    hsum_b = hsum_q;
    dly_b  = dly_q;
    if (frame_start_i) begin
      col_b  = '0;
      row_b  = '0;
      slot_b = '0;
      hsum_b = '0;
      dly_b  = '0;
    end else if (32'(col_q) >= 32'(w_eff) + 32'(r_eff)) begin
      col_b  = '0;
      row_b  = row_q + ROW_W'(1);
      slot_b = slot_q + SW'(1);
      hsum_b = '0;
      dly_b  = '0;
    end
    if (32'(slot_b) >= 32'(win)) begin
      slot_b = '0;
    end

    pix     = (mask_pixel_i != '0) && !is_padding_i;
    leaving = dly_b[SW'({r_eff, 1'b0})];
    hsum_n  = hsum_b + HW'(pix) - HW'(leaving);

    past_r = 32'(col_b) >= 32'(r_eff);
    c_full = col_b - XW'(r_eff);

    ctrl_o.load        = past_r && (32'(c_full) < 32'(w_eff));
    ctrl_o.emit        = 32'(row_b) >= 32'(r_eff);
    ctrl_o.use_old     = 32'(row_b) >= 32'(win);
    ctrl_o.frame_start = frame_start_i;

    if (32'(slot_b) >= 32'(r_eff)) begin
      cslot_o = SW'(32'(slot_b) - 32'(r_eff));
    end else begin
      cslot_o = SW'(32'(slot_b) + 32'(win) - 32'(r_eff));
    end
  end

  assign pix_o       = pix;
  assign centre_we_o = 32'(col_b) < 32'(w_eff);
  assign x_o         = col_b[CW-1:0];
  assign col_o       = c_full[CW-1:0];
  assign slot_o      = slot_b;
  assign hsum_o      = hsum_n;
  assign out_row_o   = mdbf_pkg::POS_W'(row_b - ROW_W'(r_eff));
  assign out_col_o   = mdbf_pkg::POS_W'(c_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
      hsum_q <= '0;
      dly_q  <= '0;
    end else if (accept_i) begin
      col_q  <= col_b + XW'(1);
      row_q  <= row_b;
      slot_q <= slot_b;
      hsum_q <= hsum_n;
      dly_q  <= {dly_b[WIN_MAX-2:0], pix};
    end
  end

endmodule

FILE: src/mdbf_line_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mask density box filter: line stores
// Horizontal sum store and centre bit store, one entry per line slot
// and column; read-before-write, registered read data.
// ---------------------------------------------------------------------------
module mdbf_line_mem #(
  parameter int MAX_RADIUS = mdbf_pkg::MAX_RADIUS,
  parameter int MAX_WIDTH  = mdbf_pkg::MAX_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   accept_i,
  input  mdbf_pkg::scan_ctrl_t                   ctrl_i,
  input  logic                                   pix_i,
  input  logic                                   centre_we_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]           x_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]           col_i,
  input  logic [$clog2(2*MAX_RADIUS+1)-1:0]      slot_i,
  input  logic [$clog2(2*MAX_RADIUS+1)-1:0]      cslot_i,
  input  logic [$clog2(2*MAX_RADIUS+2)-1:0]      hsum_i,
  output logic [$clog2(2*MAX_RADIUS+2)-1:0]      rs_rd_o,
  output logic                                   cb_rd_o
);

  localparam int WIN_MAX = 2 * MAX_RADIUS + 1;
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int SW      = $clog2(WIN_MAX);
  localparam int HW      = $clog2(WIN_MAX + 1);
  localparam int DEPTH   = WIN_MAX << CW;

  logic [HW-1:0] rs_mem [DEPTH];
  logic          cb_mem [DEPTH];
  logic [HW-1:0] rs_rd_q;
  logic          cb_rd_q;
  logic [SW+CW-1:0] rs_addr;

  assign rs_addr = {slot_i, col_i};

  always_ff @(posedge clk_i) begin
    if (accept_i && ctrl_i.load) begin
      rs_rd_q         <= rs_mem[rs_addr];
      rs_mem[rs_addr] <= hsum_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && centre_we_i) begin
      cb_mem[{slot_i, x_i}] <= pix_i;
    end
    if (accept_i && ctrl_i.load) begin
      cb_rd_q <= cb_mem[{cslot_i, col_i}];
    end
  end

  assign rs_rd_o = rs_rd_q;
  assign cb_rd_o = cb_rd_q;

endmodule

FILE: src/mdbf_accum.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mask density box filter: column accumulator and output stage
// Column sum memory with read-modify-write and forwarding, density
// scaling and the output register.
// ---------------------------------------------------------------------------
module mdbf_accum #(
  parameter int MAX_RADIUS = mdbf_pkg::MAX_RADIUS,
  parameter int MAX_WIDTH  = mdbf_pkg::MAX_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  mdbf_pkg::scan_ctrl_t                   ctrl_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]           col_i,
  input  logic [$clog2(2*MAX_RADIUS+2)-1:0]      hsum_i,
  input  logic [mdbf_pkg::POS_W-1:0]             out_row_i,
  input  logic [mdbf_pkg::POS_W-1:0]             out_col_i,
  input  logic [$clog2(2*MAX_RADIUS+2)-1:0]      rs_rd_i,
  input  logic                                   cb_rd_i,
  input  logic [mdbf_pkg::SCALE_W-1:0]           scale_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic [mdbf_pkg::DENS_W-1:0]            density_o,
  output logic [mdbf_pkg::POS_W-1:0]             out_row_o,
  output logic [mdbf_pkg::POS_W-1:0]             out_col_o,
  output mdbf_pkg::accum_stat_t                  stat_o
);

  localparam int WIN_MAX = 2 * MAX_RADIUS + 1;
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int FW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(WIN_MAX + 1);
  localparam int CSW     = $clog2(WIN_MAX * WIN_MAX + 1);
  localparam int PW      = CSW + mdbf_pkg::SCALE_W;
  localparam int POS_W   = mdbf_pkg::POS_W;
  localparam int DENS_W  = mdbf_pkg::DENS_W;

  logic [CSW-1:0] cs_mem [MAX_WIDTH];
  logic [CSW-1:0] cs_rd_q;

  logic             b_valid_q;
  logic             b_emit_q;
  logic             b_use_old_q;
  logic             b_zero_q;
  logic             b_fwd_q;
  logic [CSW-1:0]   b_fwd_data_q;
  logic [CW-1:0]    b_c_q;
  logic [HW-1:0]    b_hsum_q;
  logic [POS_W-1:0] b_row_q;
  logic [POS_W-1:0] b_col_q;
  logic [FW-1:0]    fill_q;

  logic             out_valid_q;
  logic [DENS_W-1:0] dens_q;
  logic [POS_W-1:0] row_q;
  logic [POS_W-1:0] col_q;

  logic             b_adv;
  logic             a_load;
  logic [FW-1:0]    fill_b;
  logic [FW-1:0]    fill_n;
  logic [CSW-1:0]   col_old;
  logic [CSW-1:0]   count;
  logic [PW-1:0]    prod;
  logic [PW-1:0]    shr;
  logic [DENS_W-1:0] dens;

  assign a_load = accept_i && ctrl_i.load;
  assign b_adv  = !b_emit_q || !out_valid_q || out_ready_i;

  always_comb begin
    fill_b = ctrl_i.frame_start ? '0 : fill_q;
    fill_n = fill_b;
    if (ctrl_i.load && (FW'(col_i) + FW'(1) > fill_b)) begin
      fill_n = FW'(col_i) + FW'(1);
    end
  end

  always_comb begin
    if (b_zero_q) begin
      col_old = '0;
    end else if (b_fwd_q) begin
      col_old = b_fwd_data_q;
    end else begin
      col_old = cs_rd_q;
    end
    count = col_old + CSW'(b_hsum_q) - (b_use_old_q ? CSW'(rs_rd_i) : '0);
    prod  = PW'(count) * PW'(scale_i);
    shr   = prod >> mdbf_pkg::SCALE_FRAC;
    if (!cb_rd_i) begin
      dens = '0;
    end else if (shr > PW'(mdbf_pkg::DENSITY_MAX)) begin
      dens = DENS_W'(mdbf_pkg::DENSITY_MAX);
    end else begin
      dens = shr[DENS_W-1:0];
    end
  end

  // column sum memory: read at accept, written back when stage B retires
  always_ff @(posedge clk_i) begin
    if (a_load) begin
      cs_rd_q <= cs_mem[col_i];
    end
    if (b_valid_q && b_adv) begin
      cs_mem[b_c_q] <= count;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      b_c_q        <= col_i;
      b_hsum_q     <= hsum_i;
      b_row_q      <= out_row_i;
      b_col_q      <= out_col_i;
      b_use_old_q  <= ctrl_i.use_old;
      b_emit_q     <= ctrl_i.emit;
      b_zero_q     <= !(FW'(col_i) < fill_b);
      b_fwd_q      <= b_valid_q && (b_c_q == col_i);
      b_fwd_data_q <= count;
    end
    if (b_valid_q && b_emit_q && b_adv) begin
      dens_q <= dens;
      row_q  <= b_row_q;
      col_q  <= b_col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        fill_q <= fill_n;
      end
      if (a_load) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_valid_q && b_emit_q && b_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign density_o      = dens_q;
  assign out_row_o      = row_q;
  assign out_col_o      = col_q;
  assign stat_o.b_valid = b_valid_q;
  assign stat_o.b_emit  = b_emit_q;
  assign stat_o.b_adv   = b_adv;

endmodule

FILE: src/mask_density_box_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mask density box filter: top level
// Windowed count of set mask pixels, scaled to 0..255.
// ---------------------------------------------------------------------------
// Usage:
//   in_i   : mask pixels in raster order over (width+radius) x (height+radius)
//            positions; frame_start marks the first position of a frame,
//            is_padding marks positions beyond the image.
//   out_o  : one density result per centre pixel (row, column), issued once
//            the window's lower-right pixel has arrived.
//   APB    : radius, line_width, scale at byte addresses 0, 4, 8; write only
//            between frames or while idle.
// Throughput: one pixel per clock while in_i.ready is high. Each loaded pixel
//   does one read-modify-write of the column sum memory and of the horizontal
//   sum store; the centre bit store takes up to one write and one read.
// Output path: a result passes the stage B registers, then the output register.
// Reset: position, running sums and column fill count clear; line stores
//   are not cleared and are written before use within each frame.
// Stall: while out_o is held, one more result can wait in the accumulate
//   stage; in_i.ready drops only when that stage also holds a result.
// ---------------------------------------------------------------------------
`include "mask_density_box_filter_assert.svh"

module mask_density_box_filter #(
  parameter int MAX_RADIUS = mdbf_pkg::MAX_RADIUS,
  parameter int MAX_WIDTH  = mdbf_pkg::MAX_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mdbf_in_if.sink                      in_i,
  mdbf_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mdbf_pkg::ADDR_W-1:0]  paddr,
  input  logic [mdbf_pkg::DATA_W-1:0]  pwdata,
  output logic [mdbf_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int WIN_MAX = 2 * MAX_RADIUS + 1;
  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int SW      = $clog2(WIN_MAX);
  localparam int HW      = $clog2(WIN_MAX + 1);

  logic [mdbf_pkg::RADIUS_W-1:0] radius;
  logic [mdbf_pkg::LWIDTH_W-1:0] line_width;
  logic [mdbf_pkg::SCALE_W-1:0]  scale;

  mdbf_pkg::scan_ctrl_t  ctrl;
  mdbf_pkg::accum_stat_t stat;

  logic                         accept;
  logic                         pix;
  logic                         centre_we;
  logic [CW-1:0]                x;
  logic [CW-1:0]                col;
  logic [SW-1:0]                slot;
  logic [SW-1:0]                cslot;
  logic [HW-1:0]                hsum;
  logic [HW-1:0]                rs_rd;
  logic                         cb_rd;
  logic [mdbf_pkg::POS_W-1:0]   a_row;
  logic [mdbf_pkg::POS_W-1:0]   a_col;

  assign in_i.ready = !stat.b_valid || stat.b_adv;
  assign accept     = in_i.valid && in_i.ready;

  mdbf_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .radius_o     (radius),
    .line_width_o (line_width),
    .scale_o      (scale)
  );

  mdbf_scan #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .mask_pixel_i  (in_i.mask_pixel),
    .is_padding_i  (in_i.is_padding),
    .frame_start_i (in_i.frame_start),
    .radius_i      (radius),
    .line_width_i  (line_width),
    .ctrl_o        (ctrl),
    .pix_o         (pix),
    .centre_we_o   (centre_we),
    .x_o           (x),
    .col_o         (col),
    .slot_o        (slot),
    .cslot_o       (cslot),
    .hsum_o        (hsum),
    .out_row_o     (a_row),
    .out_col_o     (a_col)
  );

  mdbf_line_mem #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_line_mem (
    .clk_i       (clk_i),
    .accept_i    (accept),
    .ctrl_i      (ctrl),
    .pix_i       (pix),
    .centre_we_i (centre_we),
    .x_i         (x),
    .col_i       (col),
    .slot_i      (slot),
    .cslot_i     (cslot),
    .hsum_i      (hsum),
    .rs_rd_o     (rs_rd),
    .cb_rd_o     (cb_rd)
  );

  mdbf_accum #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .ctrl_i      (ctrl),
    .col_i       (col),
    .hsum_i      (hsum),
    .out_row_i   (a_row),
    .out_col_i   (a_col),
    .rs_rd_i     (rs_rd),
    .cb_rd_i     (cb_rd),
    .scale_i     (scale),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .density_o   (out_o.density),
    .out_row_o   (out_o.out_row),
    .out_col_o   (out_o.out_col),
    .stat_o      (stat)
  );

  // a blocked result in stage B means the output register is full and held
  `MDBF_ASSERT_IMP(a_stall_cause, clk_i, rst_ni,
                   stat.b_valid && stat.b_emit && !stat.b_adv,
                   out_o.valid && !out_o.ready)
  // a blocked stage B keeps its entry
  `MDBF_ASSERT_NXT(a_stall_hold, clk_i, rst_ni,
                   stat.b_valid && !stat.b_adv, stat.b_valid)
  // a new result only comes from an emitting stage B entry
  `MDBF_ASSERT_IMP(a_out_source, clk_i, rst_ni,
                   $rose(out_o.valid), $past(stat.b_valid && stat.b_emit))

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Mask density box filter: testbench
// Streams mask frames of random size and content through the filter and
// checks every density result against a cycle-free model of the window
// counts. Register settings change between frames over APB, each write read
// back. Pixel and result channels idle and stall at random in phases 1 to 3 of four.
// ---------------------------------------------------------------------------

class density_scoreboard;
  typedef struct packed {
    logic [mdbf_pkg::DENS_W-1:0] density;
    logic [mdbf_pkg::POS_W-1:0]  out_row;
    logic [mdbf_pkg::POS_W-1:0]  out_col;
  } density_t;

  localparam int WIN_SLOTS = 2 * mdbf_pkg::MAX_RADIUS + 1;

  density_t densities_due[$];
  int errors            = 0;
  int pixels_taken      = 0;
  int densities_checked = 0;

  bit [mdbf_pkg::RADIUS_W-1:0] cfg_radius = mdbf_pkg::RADIUS_RST;
  bit [mdbf_pkg::LWIDTH_W-1:0] cfg_width  = mdbf_pkg::LWIDTH_RST;
  bit [mdbf_pkg::SCALE_W-1:0]  cfg_scale  = mdbf_pkg::SCALE_RST;

  bit [4:0] row_run;
  bit       tap_line [WIN_SLOTS];
  bit [4:0] row_sums [WIN_SLOTS * mdbf_pkg::MAX_WIDTH];
  bit       centre_lines [WIN_SLOTS * mdbf_pkg::MAX_WIDTH];
  bit [9:0] col_counts [mdbf_pkg::MAX_WIDTH];
  bit [mdbf_pkg::ROW_W-1:0] cur_row;
  int       cur_col  = 0;
  int       cur_slot = 0;

  function int eff_radius();
    if (cfg_radius == 0) return 1;
    if (cfg_radius > mdbf_pkg::MAX_RADIUS) return mdbf_pkg::MAX_RADIUS;
    return int'(cfg_radius);
  endfunction

  function int eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > mdbf_pkg::MAX_WIDTH) return mdbf_pkg::MAX_WIDTH;
    return int'(cfg_width);
  endfunction

  // returns the value a read of the register should give back
  function logic [31:0] set_reg(mdbf_pkg::reg_idx_e idx, logic [31:0] value);
    case (idx)
      mdbf_pkg::REG_RADIUS: begin
        cfg_radius = value[mdbf_pkg::RADIUS_W-1:0];
        return 32'(cfg_radius);
      end
      mdbf_pkg::REG_LINE_WIDTH: begin
        cfg_width = value[mdbf_pkg::LWIDTH_W-1:0];
        return 32'(cfg_width);
      end
      mdbf_pkg::REG_SCALE: begin
        cfg_scale = value[mdbf_pkg::SCALE_W-1:0];
        return 32'(cfg_scale);
      end
      default: ;
    endcase
    return '0;
  endfunction

  function void restart_row();
    row_run = '0;
    foreach (tap_line[i]) tap_line[i] = 1'b0;
    cur_col = 0;
  endfunction

  function void take_pixel(logic [7:0] value, logic pad, logic fs);
    int r, w, win, x, c, cslot;
    bit px, leaving;
    bit [4:0] old;
    bit [9:0] count;
    bit [63:0] prod;
    density_t due;
    r   = eff_radius();
    w   = eff_width();
    win = 2 * r + 1;
    pixels_taken++;
    if (fs) begin
      foreach (col_counts[i]) col_counts[i] = '0;
      restart_row();
      cur_row  = '0;
      cur_slot = 0;
    end else if (cur_col >= w + r) begin
      restart_row();
      cur_row  = cur_row + 1'b1;
      cur_slot = cur_slot + 1;
    end
    if (cur_slot >= win) cur_slot = 0;

    x  = cur_col;
    px = (value != 0) && !pad;
    leaving = tap_line[2 * r];
    for (int k = 2 * r; k > 0; k--) tap_line[k] = tap_line[k - 1];
    tap_line[0] = px;
    row_run = row_run + px - leaving;
    if (x < w) centre_lines[cur_slot * mdbf_pkg::MAX_WIDTH + x] = px;
    cur_col = x + 1;

    if (x < r) return;
    c = x - r;
    if (c >= w) return;
    old = (cur_row >= win) ? row_sums[cur_slot * mdbf_pkg::MAX_WIDTH + c] : 5'd0;
    row_sums[cur_slot * mdbf_pkg::MAX_WIDTH + c] = row_run;
    count = col_counts[c] + row_run - old;
    col_counts[c] = count;
    if (cur_row < r) return;

    cslot = (cur_slot >= r) ? cur_slot - r : cur_slot + win - r;
    prod  = (64'(count) * 64'(cfg_scale)) >> mdbf_pkg::SCALE_FRAC;
    if (!centre_lines[cslot * mdbf_pkg::MAX_WIDTH + c])
      due.density = '0;
    else if (prod > mdbf_pkg::DENSITY_MAX)
      due.density = mdbf_pkg::DENS_W'(mdbf_pkg::DENSITY_MAX);
    else
      due.density = prod[mdbf_pkg::DENS_W-1:0];
    due.out_row = mdbf_pkg::POS_W'(int'(cur_row) - r);
    due.out_col = mdbf_pkg::POS_W'(c);
    densities_due.push_back(due);
  endfunction

  function void check_density(logic [7:0] density, logic [9:0] out_row,
                              logic [9:0] out_col);
    density_t due;
    if (densities_due.size() == 0) begin
      $error("unexpected result: density %0d row %0d col %0d", density, out_row, out_col);
      errors++;
      return;
    end
    due = densities_due.pop_front();
    densities_checked++;
    if (density !== due.density) begin
      $error("density: expected %0d, got %0d", due.density, density);
      errors++;
    end
    if (out_row !== due.out_row) begin
      $error("out_row: expected %0d, got %0d", due.out_row, out_row);
      errors++;
    end
    if (out_col !== due.out_col) begin
      $error("out_col: expected %0d, got %0d", due.out_col, out_col);
      errors++;
    end
  endfunction
endclass

module tb;
  import mdbf_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_PIXELS = 190;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  mdbf_in_if  pix_if ();
  mdbf_out_if dens_if ();

  density_scoreboard sb;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stale_cycles   = 0;
  int n_modes        = 0;

  mask_density_box_filter u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (pix_if),
    .out_o   (dens_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    dens_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready)
        sb.take_pixel(pix_if.mask_pixel, pix_if.is_padding, pix_if.frame_start);
      if (dens_if.valid && dens_if.ready)
        sb.check_density(dens_if.density, dens_if.out_row, dens_if.out_col);
      if ((pix_if.valid && pix_if.ready) || (dens_if.valid && dens_if.ready))
        stale_cycles <= 0;
      else
        stale_cycles <= stale_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stale_cycles >= STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int window_scale(input int r);
    int area;
    area = (2 * r + 1) * (2 * r + 1);
    return ((DENSITY_MAX << SCALE_FRAC) + area - 1) / area;
  endfunction

  task automatic apb_xfer(input bit wr, input reg_idx_e idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    logic [31:0] held, back;
    apb_xfer(1'b1, idx, value, back);
    held = sb.set_reg(idx, value);
    apb_xfer(1'b0, idx, '0, back);
    if (back !== held) begin
      $error("%s readback: expected %0d, got %0d", idx.name(), held, back);
      sb.errors++;
    end
  endtask

  // registers only change once the filter has drained
  task automatic set_mode(input int radius_val, input int width_val, input int scale_val);
    pix_if.valid <= 1'b0;
    while (sb.densities_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_reg(REG_RADIUS, radius_val);
    write_reg(REG_LINE_WIDTH, width_val);
    write_reg(REG_SCALE, scale_val);
    n_modes++;
  endtask

  task automatic send_pixel(input logic [7:0] value, input logic pad, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid       <= 1'b1;
    pix_if.mask_pixel  <= value;
    pix_if.is_padding  <= pad;
    pix_if.frame_start <= fs;
    do @(posedge clk_i); while (pix_if.ready !== 1'b1);
  endtask

  // raster frame over (w+r) x rows; a few flipped pad flags, stray frame
  // starts and early cut-offs act as noise
  task automatic send_frame(input int rows, input bit lead_fs);
    int r, w, h, fill, total, stop_at, n;
    bit pad;
    logic [7:0] value;
    r       = sb.eff_radius();
    w       = sb.eff_width();
    h       = rows - r;
    fill    = ($urandom_range(3) == 0) ? 100 : $urandom_range(100);
    total   = (w + r) * rows;
    stop_at = ($urandom_range(5) == 0) ? $urandom_range(total - 1) : total;
    n       = 0;
    for (int y = 0; y < rows; y++) begin
      for (int x = 0; x < w + r; x++) begin
        if (n == stop_at) return;
        pad = (x >= w) || (y >= h);
        if ($urandom_range(99) < 3) pad = !pad;
        value = ($urandom_range(99) < fill) ? 8'($urandom_range(255, 1)) : 8'h00;
        send_pixel(value, pad, (lead_fs && n == 0) || ($urandom_range(199) == 0));
        n++;
      end
    end
  endtask

  initial begin : stimulus
    int r, w, s, target;
    sb = new();
    pix_if.valid       = 1'b0;
    pix_if.mask_pixel  = '0;
    pix_if.is_padding  = 1'b0;
    pix_if.frame_start = 1'b0;
    dens_if.ready      = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
        3:       begin send_idle_pct = 34; recv_stall_pct = 34; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      case (ph)
        0: begin
          // 2x2 image with padding column and row, padded pixels mostly set
          set_mode(1, 2, window_scale(1));
          send_pixel(8'hff, 1'b0, 1'b1);
          send_pixel(8'h01, 1'b0, 1'b0);
          send_pixel(8'hff, 1'b1, 1'b0);
          send_pixel(8'h80, 1'b0, 1'b0);
          send_pixel(8'h00, 1'b0, 1'b0);
          send_pixel(8'h7f, 1'b1, 1'b0);
          send_pixel(8'h01, 1'b1, 1'b0);
          send_pixel(8'hff, 1'b1, 1'b0);
          send_pixel(8'h00, 1'b1, 1'b0);
          // zero radius and width clamp to 1, full scale saturates
          set_mode(0, 0, 24'hffffff);
          send_pixel(8'hff, 1'b0, 1'b1);
          send_pixel(8'hff, 1'b1, 1'b0);
          send_pixel(8'hfe, 1'b0, 1'b0);
          send_pixel(8'h00, 1'b1, 1'b0);
          send_pixel(8'h01, 1'b0, 1'b0);
          send_pixel(8'hff, 1'b1, 1'b0);
          send_pixel(8'hff, 1'b0, 1'b1);
          send_pixel(8'h40, 1'b0, 1'b0);
          send_pixel(8'h00, 1'b0, 1'b0);
          send_pixel(8'hff, 1'b0, 1'b0);
          send_pixel(8'h02, 1'b0, 1'b0);
        end
        1: begin
          set_mode(MAX_RADIUS, $urandom_range(1, 3), window_scale(MAX_RADIUS));
          send_frame(MAX_RADIUS + 1 + $urandom_range(1), 1'b1);
        end
        2: begin
          set_mode(1, MAX_WIDTH, window_scale(1));
          send_frame(2, 1'b1);
        end
        default: begin
          // oversized width clamps to the line store size
          set_mode(0, 2047, 24'hffffff);
          send_frame(2, 1'b1);
        end
      endcase

      target = sb.pixels_taken + PHASE_PIXELS;
      while (sb.pixels_taken < target) begin
        r = $urandom_range(1, 4);
        w = $urandom_range(1, 12);
        case ($urandom_range(7))
          0:       s = $urandom() & 32'h00ff_ffff;
          1:       s = 0;
          2:       s = 24'hffffff;
          default: s = window_scale(r);
        endcase
        set_mode(r, w, s);
        send_frame(r + 1 + $urandom_range(4), 1'b1);
        repeat ($urandom_range(2))
          send_frame(r + 1 + $urandom_range(4), $urandom_range(7) != 0);
      end
    end

    pix_if.valid <= 1'b0;
    while (sb.densities_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Streamed %0d mask pixels over %0d register settings, %0d densities compared.",
             sb.pixels_taken, n_modes, sb.densities_checked);
    $display("Radius 1..15 and widths 1..1024 incl. clamped values, under four idle/stall mixes.");
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+src
src/mdbf_pkg.sv
src/mdbf_if.sv
src/mdbf_cfg.sv
src/mdbf_scan.sv
src/mdbf_line_mem.sv
src/mdbf_accum.sv
src/mask_density_box_filter.sv
sim/tb.sv
